// ===== hdl/weighted_degree_string_similarity_defines.svh =====
// Assertion macros shared by the weighted-degree similarity block.
`ifndef WEIGHTED_DEGREE_STRING_SIMILARITY_DEFINES_SVH
`define WEIGHTED_DEGREE_STRING_SIMILARITY_DEFINES_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define WDSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, disabled in reset.
`define WDSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wdss_pkg.sv =====
// Types, constants and codes shared by the weighted-degree similarity block.
package wdss_pkg;

  localparam int SYM_W      = 8;
  localparam int MO_W       = 6;
  localparam int SO_W       = 5;
  localparam int WO_W       = 8;
  localparam int SUM_W      = 30;
  localparam int SCORE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QUO_W      = 33;
  localparam int DIV_STEPS  = 33;
  localparam int DCNT_W     = 6;

  localparam int ORDER_LIMIT_DEF  = 32;
  localparam int LENGTH_LIMIT_DEF = 65535;

  localparam logic [SUM_W-1:0]   SUM_MAX   = 30'h3FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 32'h8000_0000;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ORDER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ORDER = 2'd2;

  localparam logic [MO_W-1:0] MAX_ORDER_RST    = 6'd8;
  localparam logic [SO_W-1:0] START_ORDER_RST  = 5'd0;
  localparam logic [WO_W-1:0] WEIGHT_ORDER_RST = 8'd8;

  typedef enum logic [2:0] {
    ST_PAIRS,
    ST_NORM,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic pair_en;    // take one symbol pair
    logic norm_init;  // zero the normalisation sum and index
    logic norm_step;  // add one normalisation term
    logic div_init;   // load the divider
    logic div_step;   // one quotient bit
    logic load;       // result to output register, clear string state
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic div_skip;
    logic div_last;
  } sts_t;

endpackage

// ===== hdl/wdss_ctrl.sv =====
// Sequencer for pair intake, normalisation, division and result hand-off.
`include "weighted_degree_string_similarity_defines.svh"

module wdss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_pair,
  input  logic           out_free,
  input  wdss_pkg::sts_t sts,
  output logic           in_stall,
  output wdss_pkg::cmd_t cmd
);

  wdss_pkg::state_t state_r;
  wdss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wdss_pkg::ST_PAIRS;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wdss_pkg::ST_PAIRS: begin
        if (in_valid && in_last_pair) state_nxt = wdss_pkg::ST_NORM;
      end
      wdss_pkg::ST_NORM: begin
        if (sts.norm_done) state_nxt = wdss_pkg::ST_CHECK;
      end
      wdss_pkg::ST_CHECK: begin
        state_nxt = sts.div_skip ? wdss_pkg::ST_DONE : wdss_pkg::ST_DIV;
      end
      wdss_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = wdss_pkg::ST_DONE;
      end
      wdss_pkg::ST_DONE: begin
        if (out_free) state_nxt = wdss_pkg::ST_PAIRS;
      end
      default: state_nxt = wdss_pkg::ST_PAIRS;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      wdss_pkg::ST_PAIRS: begin
        in_stall      = 1'b0;
        cmd.pair_en   = in_valid;
        cmd.norm_init = in_valid && in_last_pair;
      end
      wdss_pkg::ST_NORM:  cmd.norm_step = !sts.norm_done;
      wdss_pkg::ST_CHECK: cmd.div_init  = 1'b1;
      wdss_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      wdss_pkg::ST_DONE:  cmd.load      = out_free;
      default: ;
    endcase
  end

  `WDSS_ASSERT_NEXT(a_last_starts_norm, cmd.norm_init, state_r == wdss_pkg::ST_NORM, "last pair did not start normalisation")
  `WDSS_ASSERT_NEXT(a_div_runs_out, (state_r == wdss_pkg::ST_DIV) && !sts.div_last, state_r == wdss_pkg::ST_DIV, "division left early")
  `WDSS_ASSERT_NEXT(a_skip_to_done, (state_r == wdss_pkg::ST_CHECK) && sts.div_skip, state_r == wdss_pkg::ST_DONE, "skipped division did not finish")

endmodule

// ===== hdl/wdss_dp.sv =====
// Datapath: run tracking, match sum, normalisation sum and restoring divider.
module wdss_dp #(
  parameter int ORDER_LIMIT  = wdss_pkg::ORDER_LIMIT_DEF,
  parameter int LENGTH_LIMIT = wdss_pkg::LENGTH_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wdss_pkg::cmd_t                 cmd,
  input  logic [wdss_pkg::MO_W-1:0]      cfg_max_order,
  input  logic [wdss_pkg::SO_W-1:0]      cfg_start_order,
  input  logic [wdss_pkg::WO_W-1:0]      cfg_weight_order,
  input  logic [wdss_pkg::SYM_W-1:0]     symbol_a,
  input  logic [wdss_pkg::SYM_W-1:0]     symbol_b,
  output wdss_pkg::sts_t                 sts,
  output logic [wdss_pkg::SCORE_W-1:0]   score_q31,
  output logic [wdss_pkg::SUM_W-1:0]     match_total,
  output logic [wdss_pkg::SUM_W-1:0]     norm_total,
  output logic                           bad_setup
);

  localparam int PW  = $clog2(LENGTH_LIMIT + 1);
  localparam int CW  = (PW > wdss_pkg::MO_W) ? PW : wdss_pkg::MO_W;
  localparam int NPW = CW + wdss_pkg::WO_W;
  localparam int NSW = ((NPW > wdss_pkg::SUM_W) ? NPW : wdss_pkg::SUM_W) + 1;
  localparam logic [wdss_pkg::MO_W:0] OLIM    = (wdss_pkg::MO_W + 1)'(ORDER_LIMIT);
  localparam logic [PW-1:0]           LEN_MAX = PW'(LENGTH_LIMIT);

  logic [wdss_pkg::MO_W-1:0]     run_r, run_nxt;
  logic [wdss_pkg::SUM_W-1:0]    acc_r, acc_nxt;
  logic [PW-1:0]                 pos_r;
  logic [wdss_pkg::MO_W-1:0]     ni_r;
  logic [wdss_pkg::SUM_W-1:0]    norm_r, norm_nxt;
  logic [wdss_pkg::SUM_W-1:0]    rem_r, rem_nxt;
  logic [wdss_pkg::QUO_W-1:0]    dq_r;
  logic [wdss_pkg::DCNT_W-1:0]   dc_r;

  logic [wdss_pkg::MO_W-1:0]     order;
  logic [wdss_pkg::MO_W:0]       run_inc;
  logic [wdss_pkg::WO_W-1:0]     hi;
  logic                          term_on;
  logic [wdss_pkg::WO_W-1:0]     n_cnt;
  logic [9:0]                    coef;
  logic [15:0]                   tprod;
  logic [wdss_pkg::SUM_W:0]      acc_sum;
  logic [CW-1:0]                 len_m;
  logic [wdss_pkg::WO_W-1:0]     f_m;
  logic                          f_gt;
  logic [NPW-1:0]                nprod;
  logic [NSW-1:0]                nsum;
  logic [wdss_pkg::SUM_W:0]      dtry;
  logic                          dge;
  logic                          acc_ge;
  logic                          bad;

  // effective order, capped at the build limit
  assign order = (({1'b0, cfg_max_order}) > OLIM) ? OLIM[wdss_pkg::MO_W-1:0] : cfg_max_order;

  // run of matching pairs
  assign run_inc = {1'b0, run_r} + 1'b1;
  always_comb begin
    if (symbol_a == symbol_b) begin
      run_nxt = (run_inc > {1'b0, order}) ? order : run_inc[wdss_pkg::MO_W-1:0];
    end else begin
      run_nxt = '0;
    end
  end

  // sum of (F - j) for j in [s, min(run, F)) as n*(2F - s - hi + 1)/2
  assign hi      = ({2'b0, run_nxt} < cfg_weight_order) ? {2'b0, run_nxt} : cfg_weight_order;
  assign term_on = hi > {3'b0, cfg_start_order};
  assign n_cnt   = hi - {3'b0, cfg_start_order};
  assign coef    = {1'b0, cfg_weight_order, 1'b0} - {5'b0, cfg_start_order}
                 - {2'b0, hi} + 10'd1;
  assign tprod   = 16'(n_cnt[wdss_pkg::MO_W-1:0]) * 16'(coef);
  assign acc_sum = {1'b0, acc_r} + (term_on ? (wdss_pkg::SUM_W + 1)'(tprod[15:1])
                                            : '0);
  assign acc_nxt = (acc_sum > {1'b0, wdss_pkg::SUM_MAX}) ? wdss_pkg::SUM_MAX
                 : acc_sum[wdss_pkg::SUM_W-1:0];

  // normalisation term (len - i) * (F - i), one per cycle
  assign sts.norm_done = (ni_r >= order) || (CW'(ni_r) >= CW'(pos_r));
  assign len_m    = CW'(pos_r) - CW'(ni_r);
  assign f_gt     = cfg_weight_order > wdss_pkg::WO_W'(ni_r);
  assign f_m      = cfg_weight_order - wdss_pkg::WO_W'(ni_r);
  assign nprod    = f_gt ? (NPW'(len_m) * NPW'(f_m)) : '0;
  assign nsum     = NSW'(norm_r) + NSW'(nprod);
  assign norm_nxt = (nsum > NSW'(wdss_pkg::SUM_MAX)) ? wdss_pkg::SUM_MAX
                  : nsum[wdss_pkg::SUM_W-1:0];

  // setup check and divider
  assign bad    = !((({1'b0, cfg_start_order}) < order)
               && (({2'b0, order}) <= cfg_weight_order));
  assign acc_ge = {2'b0, acc_r} >= {norm_r, 2'b0};
  assign sts.div_skip = bad || (norm_r == '0) || acc_ge;
  assign sts.div_last = dc_r == wdss_pkg::DCNT_W'(wdss_pkg::DIV_STEPS - 1);

  assign dtry    = {rem_r, dq_r[wdss_pkg::QUO_W-1]};
  assign dge     = dtry >= {1'b0, norm_r};
  assign rem_nxt = dge ? 30'(dtry - {1'b0, norm_r}) : dtry[wdss_pkg::SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      acc_r <= '0;
      pos_r <= '0;
    end else if (cmd.load) begin
      run_r <= '0;
      acc_r <= '0;
      pos_r <= '0;
    end else if (cmd.pair_en) begin
      run_r <= run_nxt;
      acc_r <= acc_nxt;
      if (pos_r < LEN_MAX) pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.norm_init) begin
      ni_r   <= '0;
      norm_r <= '0;
    end else if (cmd.norm_step) begin
      ni_r   <= ni_r + 1'b1;
      norm_r <= norm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= {2'b0, acc_r[wdss_pkg::SUM_W-1:2]};
      dq_r  <= {acc_r[1:0], 31'b0};
      dc_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[wdss_pkg::QUO_W-2:0], dge};
      dc_r  <= dc_r + 1'b1;
    end
  end

  always_comb begin
    if (bad || (norm_r == '0)) begin
      score_q31 = '0;
    end else if (acc_ge || (dq_r > wdss_pkg::QUO_W'(wdss_pkg::SCORE_ONE))) begin
      score_q31 = wdss_pkg::SCORE_ONE;
    end else begin
      score_q31 = dq_r[wdss_pkg::SCORE_W-1:0];
    end
  end

  assign match_total = bad ? '0 : acc_r;
  assign norm_total  = bad ? '0 : norm_r;
  assign bad_setup   = bad;

endmodule

// ===== hdl/weighted_degree_string_similarity.sv =====
// Weighted-degree string similarity: one symbol pair per item, one result per string.
// Throughput: one pair per cycle while a string streams in.
// After the last pair is taken, the block runs the normalisation loop over lim =
// min(order, length) terms, a check, and the 33-step restoring divider, or skips the
// division, then loads the result into the output register once that register is free.
// Reset (rst_n low, synchronous): state, run, match sum and length cleared, registers 8/0/8.
module weighted_degree_string_similarity #(
  parameter int ORDER_LIMIT  = wdss_pkg::ORDER_LIMIT_DEF,
  parameter int LENGTH_LIMIT = wdss_pkg::LENGTH_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [wdss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wdss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // pair items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wdss_pkg::SYM_W-1:0]        in_symbol_a,
  input  logic [wdss_pkg::SYM_W-1:0]        in_symbol_b,
  input  logic                              in_last_pair,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wdss_pkg::SCORE_W-1:0]      out_score_q31,
  output logic [wdss_pkg::SUM_W-1:0]        out_match_total,
  output logic [wdss_pkg::SUM_W-1:0]        out_norm_total,
  output logic                              out_bad_setup
);

  logic [wdss_pkg::MO_W-1:0]    max_order_r;
  logic [wdss_pkg::SO_W-1:0]    start_order_r;
  logic [wdss_pkg::WO_W-1:0]    weight_order_r;

  wdss_pkg::cmd_t               cmd;
  wdss_pkg::sts_t               sts;
  logic                         out_free;
  logic                         out_valid_r;
  logic [wdss_pkg::SCORE_W-1:0] score_q31;
  logic [wdss_pkg::SUM_W-1:0]   match_total;
  logic [wdss_pkg::SUM_W-1:0]   norm_total;
  logic                         bad_setup;
  logic [wdss_pkg::SCORE_W-1:0] score_r;
  logic [wdss_pkg::SUM_W-1:0]   match_r;
  logic [wdss_pkg::SUM_W-1:0]   norm_r;
  logic                         bad_r;

  // configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_order_r    <= wdss_pkg::MAX_ORDER_RST;
      start_order_r  <= wdss_pkg::START_ORDER_RST;
      weight_order_r <= wdss_pkg::WEIGHT_ORDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wdss_pkg::CFG_MAX_ORDER:    max_order_r    <= cfg_wdata[wdss_pkg::MO_W-1:0];
        wdss_pkg::CFG_START_ORDER:  start_order_r  <= cfg_wdata[wdss_pkg::SO_W-1:0];
        wdss_pkg::CFG_WEIGHT_ORDER: weight_order_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  wdss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_pair (in_last_pair),
    .out_free     (out_free),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  wdss_dp #(
    .ORDER_LIMIT  (ORDER_LIMIT),
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_max_order    (max_order_r),
    .cfg_start_order  (start_order_r),
    .cfg_weight_order (weight_order_r),
    .symbol_a         (in_symbol_a),
    .symbol_b         (in_symbol_b),
    .sts              (sts),
    .score_q31        (score_q31),
    .match_total      (match_total),
    .norm_total       (norm_total),
    .bad_setup        (bad_setup)
  );

  // result register: holds while stalled, new pairs may stream meanwhile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      score_r <= score_q31;
      match_r <= match_total;
      norm_r  <= norm_total;
      bad_r   <= bad_setup;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_score_q31   = score_r;
  assign out_match_total = match_r;
  assign out_norm_total  = norm_r;
  assign out_bad_setup   = bad_r;

endmodule

// ===== tb/sv/tb_weighted_degree_string_similarity.sv =====
// Self-checking testbench for the weighted-degree string similarity block.
module tb_weighted_degree_string_similarity;
  import wdss_pkg::*;

  // Predictor copies of the block's order and length caps.
  localparam int ORDER_CAP     = ORDER_LIMIT_DEF;
  localparam int LENGTH_CAP    = LENGTH_LIMIT_DEF;
  // Settle time after a drain, longer than the slowest result takes.
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  // Watchdog time: a run still going at this point is reported as failed.
  localparam int RUN_LIMIT     = 2_400_000;

  typedef longint unsigned u64_t;

  // One symbol pair as the sender offers it.
  typedef struct packed {
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    logic             last;
  } pair_item_t;

  // One string result as the block should report it.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [SUM_W-1:0]   match;
    logic [SUM_W-1:0]   norm;
    logic               bad;
  } sim_result_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_MAX_ORDER;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic [SYM_W-1:0]      in_symbol_a  = '0;
  logic [SYM_W-1:0]      in_symbol_b  = '0;
  logic                  in_last_pair = 1'b0;
  logic                  out_stall    = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [SCORE_W-1:0]    out_score_q31;
  logic [SUM_W-1:0]      out_match_total;
  logic [SUM_W-1:0]      out_norm_total;
  logic                  out_bad_setup;

  weighted_degree_string_similarity i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol_a     (in_symbol_a),
    .in_symbol_b     (in_symbol_b),
    .in_last_pair    (in_last_pair),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_score_q31   (out_score_q31),
    .out_match_total (out_match_total),
    .out_norm_total  (out_norm_total),
    .out_bad_setup   (out_bad_setup)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies plus the per-string run, sum and length.
  // Registers only change while the block is idle, so plain copies suffice.
  // ---------------------------------------------------------------------------
  logic [MO_W-1:0] reg_max_order    = MAX_ORDER_RST;
  logic [SO_W-1:0] reg_start_order  = START_ORDER_RST;
  logic [WO_W-1:0] reg_weight_order = WEIGHT_ORDER_RST;
  int unsigned     run_len          = 0;
  int unsigned     pos_cnt          = 0;
  u64_t            match_acc        = 0;

  pair_item_t  pending_pairs[$];    // items waiting for the sender
  sim_result_t expected_scores[$];  // results predicted, not yet seen

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic rx_hold      = 1'b0;
  bit   hold_trigger = 1'b0;
  int   mismatches   = 0;

  pair_item_t  next_pair;
  sim_result_t pair_result;
  sim_result_t want;

  // Advance the predictor by one accepted pair; returns 1 when a result is due.
  function automatic bit score_pair(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                                    input logic last, output sim_result_t r);
    int unsigned order;
    int unsigned s;
    int unsigned f;
    int unsigned lim;
    u64_t        norm;
    u64_t        quo;
    bit          bad;
    order = (reg_max_order > ORDER_CAP) ? ORDER_CAP : reg_max_order;
    s     = reg_start_order;
    f     = reg_weight_order;
    r     = '0;

    // run of matching pairs, capped at the order
    if (a == b) begin
      run_len++;
      if (run_len > order) run_len = order;
    end else begin
      run_len = 0;
    end

    // weights (F - j) over run offsets from the start order; terms <= 0 add nothing
    for (int unsigned j = s; j < run_len; j++) begin
      if (f > j) match_acc += u64_t'(f - j);
    end
    if (match_acc > SUM_MAX) match_acc = SUM_MAX;

    if (pos_cnt < LENGTH_CAP) pos_cnt++;

    if (!last) return 1'b0;

    bad = !(s < order && order <= f);
    if (bad) begin
      r.bad = 1'b1;
    end else begin
      // normalisation: orders at or above the length add nothing
      lim  = (order < pos_cnt) ? order : pos_cnt;
      norm = 0;
      for (int unsigned i = 0; i < lim && norm <= SUM_MAX; i++) begin
        if (f > i) norm += u64_t'(pos_cnt - i) * u64_t'(f - i);
      end
      if (norm > SUM_MAX) norm = SUM_MAX;
      if (norm != 0) begin
        quo     = (match_acc << 31) / norm;
        r.score = (quo > SCORE_ONE) ? SCORE_ONE : quo[SCORE_W-1:0];
      end
      r.match = match_acc[SUM_W-1:0];
      r.norm  = norm[SUM_W-1:0];
    end

    run_len   = 0;
    match_acc = 0;
    pos_cnt   = 0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string field, input u64_t want_v, input u64_t got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: predicts on every accepted item, then offers the next queued item
  // unless it chooses to idle. A stalled item is held unchanged.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (score_pair(in_symbol_a, in_symbol_b, in_last_pair, pair_result))
          expected_scores.push_back(pair_result);
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_pair    = pending_pairs.pop_front();
          in_valid     <= 1'b1;
          in_symbol_a  <= next_pair.a;
          in_symbol_b  <= next_pair.b;
          in_last_pair <= next_pair.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted result against the oldest prediction, then
  // picks the next stall value (random idling, or the long hold-off).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_scores.size() == 0) begin
          flag_mismatch("unexpected result, score_q31", 0, out_score_q31);
        end else begin
          want = expected_scores.pop_front();
          if (out_score_q31 !== want.score)
            flag_mismatch("score_q31", want.score, out_score_q31);
          if (out_match_total !== want.match)
            flag_mismatch("match_total", want.match, out_match_total);
          if (out_norm_total !== want.norm)
            flag_mismatch("norm_total", want.norm, out_norm_total);
          if (out_bad_setup !== want.bad)
            flag_mismatch("bad_setup", want.bad, out_bad_setup);
        end
      end
      out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the block backs up.
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("** weighted_degree_string_similarity: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAX_ORDER:    reg_max_order    = value[MO_W-1:0];
      CFG_START_ORDER:  reg_start_order  = value[SO_W-1:0];
      CFG_WEIGHT_ORDER: reg_weight_order = value[WO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned mo, input int unsigned so, input int unsigned wo);
    write_reg(CFG_MAX_ORDER, mo);
    write_reg(CFG_START_ORDER, so);
    write_reg(CFG_WEIGHT_ORDER, wo);
  endtask

  // Mostly well-formed setups, a fifth anything the register widths allow but a zero weight order.
  task automatic random_config();
    int unsigned ord;
    int unsigned mo;
    int unsigned so;
    int unsigned wo;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      ord = $urandom_range(1, ORDER_CAP);
      so  = (pick < 30) ? 0 : $urandom_range(0, ord - 1);
      wo  = (pick % 3 == 0) ? $urandom_range(ord, ord + 3) : $urandom_range(ord, 255);
      mo  = (ord == ORDER_CAP && pick[0]) ? $urandom_range(ORDER_CAP, 63) : ord;
    end else begin
      mo = $urandom_range(0, 63);
      so = $urandom_range(0, 31);
      wo = $urandom_range(1, 255);
    end
    set_config(mo, so, wo);
  endtask

  task automatic push_pair(input int unsigned a, input int unsigned b, input bit last);
    pair_item_t p;
    p.a    = a[SYM_W-1:0];
    p.b    = b[SYM_W-1:0];
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  // Random string; match_pct sets how often the second symbol copies the first.
  task automatic queue_string(input int unsigned len, input int unsigned match_pct);
    int unsigned a;
    int unsigned b;
    for (int unsigned k = 0; k < len; k++) begin
      a = $urandom_range(0, 255);
      b = ($urandom_range(0, 99) < match_pct) ? a : $urandom_range(0, 255);
      push_pair(a, b, k == len - 1);
    end
  endtask

  task automatic queue_strings(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 45);
      queue_string(len, $urandom_range(0, 100));
      sent += len;
    end
  endtask

  // Wait until every item is taken and every result seen, then let the block settle.
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int tx, input int rx);
    tx_idle_pct <= tx;
    rx_idle_pct <= rx;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(25, 79);

    // Reset registers (order 8, start 0, F 8): single pair, mixed string, runs.
    push_pair(0, 0, 1);
    push_pair(255, 255, 0);
    push_pair(0, 255, 0);
    push_pair(170, 170, 1);
    push_pair(1, 1, 0);
    push_pair(2, 2, 0);
    push_pair(1, 3, 0);
    push_pair(4, 4, 0);
    push_pair(4, 4, 0);
    push_pair(85, 85, 1);
    drain();

    // Order 2, widest weight: runs capped at two, then a lone mismatch.
    set_config(2, 0, 255);
    for (int k = 0; k < 5; k++) push_pair(15, 15, k == 4);
    push_pair(0, 255, 1);
    drain();

    // Order field above the limit, highest start order: short string scores 0.
    set_config(63, 31, 255);
    push_pair(240, 240, 0);
    push_pair(7, 7, 1);
    drain();

    // Smallest sound setup: order 1, F 1.
    set_config(1, 0, 1);
    for (int k = 0; k < 3; k++) push_pair(128, 128, k == 2);
    drain();

    // Bad setups: order zero, start equal to order, order above F.
    set_config(0, 0, 8);
    push_pair(9, 9, 1);
    drain();
    set_config(8, 8, 8);
    push_pair(9, 9, 1);
    drain();
    set_config(9, 0, 8);
    push_pair(9, 9, 1);
    drain();

    // Random part: sender light / receiver heavy, swapped, then no idling.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       set_idle(25, 79);
        1:       set_idle(79, 25);
        default: set_idle(0, 0);
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        random_config();
        if (mode == 2 && ph == 0) begin
          queue_strings(120);
          hold_trigger = 1'b1;
        end else begin
          queue_strings(50);
        end
        drain();
      end
    end

    if (mismatches == 0 && expected_scores.size() == 0)
      $display("** weighted_degree_string_similarity: PASSED **");
    else
      $display("** weighted_degree_string_similarity: FAILED **");
    $finish;
  end

endmodule
